/* sv/tsd_pkg.sv */
// Package for the triangle signed distance block.
// Holds shared widths, latencies, register indexes, sign codes and geometry types.
// Used by tsd_cfg, tsd_edge, tsd_sqrt and the top level; depends on nothing.
package tsd_pkg;

    localparam int COORD_W   = 16;
    localparam int VEC_W     = 17;
    localparam int SQ_W      = 34;
    localparam int DOT_W     = 35;
    localparam int D2_W      = 36;
    localparam int OCR_W     = 36;
    localparam int T_BITS    = 30;
    localparam int OUT_W     = 18;
    localparam int ROOT_W    = 19;
    localparam int ROOT_STEPS = 18;
    localparam int EDGE_LAT  = 3 + T_BITS + 4;
    localparam int SQRT_LAT  = ROOT_STEPS + 1;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int REG_COUNT = 6;
    localparam int OUT_MAX   = 131071;

    localparam logic [2:0] REG_A_X = 3'd0;
    localparam logic [2:0] REG_A_Y = 3'd1;
    localparam logic [2:0] REG_B_X = 3'd2;
    localparam logic [2:0] REG_B_Y = 3'd3;
    localparam logic [2:0] REG_C_X = 3'd4;
    localparam logic [2:0] REG_C_Y = 3'd5;

    typedef enum logic [1:0] {
        SGN_ZERO,
        SGN_POS,
        SGN_NEG
    } sign_t;

    typedef struct packed {
        logic [COORD_W-1:0] vtx_x;
        logic [COORD_W-1:0] vtx_y;
        logic [VEC_W-1:0]   ex;
        logic [VEC_W-1:0]   ey;
        logic [SQ_W-1:0]    ee;
    } edge_geom_t;

    typedef struct packed {
        edge_geom_t [2:0] edges;
        sign_t            orient;
    } geom_t;

endpackage

/* sv/tsd_query_if.sv */
// Query channel interface: valid/ready handshake with the query point payload.
// Depends on nothing.
interface tsd_query_if #(
    parameter int COORD_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] query_x;
    logic [COORD_BITS-1:0] query_y;

    modport source (output valid, output query_x, output query_y, input ready);
    modport sink (input valid, input query_x, input query_y, output ready);
endinterface

/* sv/tsd_result_if.sv */
// Result channel interface: valid/ready handshake with the signed distance payload.
// Depends on nothing.
interface tsd_result_if ();
    logic        valid;
    logic        ready;
    logic [17:0] signed_distance;

    modport source (output valid, output signed_distance, input ready);
    modport sink (input valid, input signed_distance, output ready);
endinterface

/* sv/tsd_cfg.sv */
// APB vertex registers and the geometry derived from them (edges, lengths, orientation).
// Depends on tsd_pkg.
module tsd_cfg #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsd_pkg::DATA_W-1:0]  pwdata,
    output logic [tsd_pkg::DATA_W-1:0]  prdata,
    output tsd_pkg::geom_t              geom
);
    localparam int SHIFT = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;

    logic [COORD_BITS-1:0] raw_reg [tsd_pkg::REG_COUNT];
    logic [2:0]            idx;
    logic signed [15:0]    crd [tsd_pkg::REG_COUNT];
    logic signed [16:0]    ex [3];
    logic signed [16:0]    ey [3];
    logic signed [16:0]    ex_reg [3];
    logic signed [16:0]    ey_reg [3];
    logic [33:0]           sqx_reg [3];
    logic [33:0]           sqy_reg [3];
    logic [33:0]           ee_reg [3];
    logic signed [33:0]    or1_reg;
    logic signed [33:0]    or2_reg;
    logic signed [34:0]    or_diff;
    tsd_pkg::sign_t        orient_reg;

    assign idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tsd_pkg::REG_COUNT; i++)
            begin
                raw_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                tsd_pkg::REG_A_X: raw_reg[0] <= pwdata[COORD_BITS-1:0];
                tsd_pkg::REG_A_Y: raw_reg[1] <= pwdata[COORD_BITS-1:0];
                tsd_pkg::REG_B_X: raw_reg[2] <= pwdata[COORD_BITS-1:0];
                tsd_pkg::REG_B_Y: raw_reg[3] <= pwdata[COORD_BITS-1:0];
                tsd_pkg::REG_C_X: raw_reg[4] <= pwdata[COORD_BITS-1:0];
                tsd_pkg::REG_C_Y: raw_reg[5] <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            tsd_pkg::REG_A_X: prdata = 32'(raw_reg[0]);
            tsd_pkg::REG_A_Y: prdata = 32'(raw_reg[1]);
            tsd_pkg::REG_B_X: prdata = 32'(raw_reg[2]);
            tsd_pkg::REG_B_Y: prdata = 32'(raw_reg[3]);
            tsd_pkg::REG_C_X: prdata = 32'(raw_reg[4]);
            tsd_pkg::REG_C_Y: prdata = 32'(raw_reg[5]);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < tsd_pkg::REG_COUNT; i++)
        begin
            crd[i] = 16'($signed(raw_reg[i]) >>> SHIFT);
        end
        for (int i = 0; i < 3; i++)
        begin
            ex[i] = 17'(crd[(2 * i + 2) % 6]) - 17'(crd[2 * i]);
            ey[i] = 17'(crd[(2 * i + 3) % 6]) - 17'(crd[2 * i + 1]);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            ex_reg[i]  <= ex[i];
            ey_reg[i]  <= ey[i];
            sqx_reg[i] <= 34'(34'(ex[i]) * 34'(ex[i]));
            sqy_reg[i] <= 34'(34'(ey[i]) * 34'(ey[i]));
            ee_reg[i]  <= sqx_reg[i] + sqy_reg[i];
        end
        or1_reg <= 34'(ex[0]) * 34'(ey[2]);
        or2_reg <= 34'(ey[0]) * 34'(ex[2]);
        if (or_diff > 0)
        begin
            orient_reg <= tsd_pkg::SGN_POS;
        end
        else if (or_diff < 0)
        begin
            orient_reg <= tsd_pkg::SGN_NEG;
        end
        else
        begin
            orient_reg <= tsd_pkg::SGN_ZERO;
        end
    end

    assign or_diff = 35'(or1_reg) - 35'(or2_reg);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            geom.edges[i].vtx_x = crd[2 * i];
            geom.edges[i].vtx_y = crd[2 * i + 1];
            geom.edges[i].ex    = ex_reg[i];
            geom.edges[i].ey    = ey_reg[i];
            geom.edges[i].ee    = ee_reg[i];
        end
        geom.orient = orient_reg;
    end

endmodule

/* sv/tsd_edge.sv */
// Pipelined distance to one edge: projection, restoring divider, scaling and squares.
// Depends on tsd_pkg.
module tsd_edge (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [15:0]         qx,
    input  logic signed [15:0]         qy,
    input  tsd_pkg::edge_geom_t        g,
    output logic [tsd_pkg::D2_W-1:0]   d2,
    output logic signed [34:0]         cr
);
    localparam int TB = tsd_pkg::T_BITS;

    typedef struct packed {
        logic [34:0]   rem;
        logic [TB-1:0] quo;
        logic          tz;
        logic          tone;
        logic [16:0]   vx;
        logic [16:0]   vy;
        logic [34:0]   cr;
    } div_t;

    logic signed [16:0] vx1_reg, vy1_reg;
    logic signed [16:0] vx2_reg, vy2_reg;
    logic signed [33:0] pvx_reg, pvy_reg, pc1_reg, pc2_reg;
    logic signed [34:0] ve;
    div_t               div_s [TB+1];
    div_t               d3_next;

    logic [47:0]        magx_reg, magy_reg;
    logic               negx_reg, negy_reg;
    logic signed [16:0] mvx_reg, mvy_reg;
    logic signed [34:0] cr1_reg, cr2_reg, cr3_reg, cr4_reg;
    logic [30:0]        t_val;
    logic [16:0]        absx, absy;
    logic [16:0]        sx, sy;
    logic signed [17:0] sxs, sys;
    logic signed [17:0] px_reg, py_reg;
    logic [35:0]        sqx_reg, sqy_reg;
    logic [35:0]        d2_reg;
    div_t               dl;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vx1_reg <= 17'(qx) - 17'($signed(g.vtx_x));
            vy1_reg <= 17'(qy) - 17'($signed(g.vtx_y));
            vx2_reg <= vx1_reg;
            vy2_reg <= vy1_reg;
            pvx_reg <= 34'(vx1_reg) * 34'($signed(g.ex));
            pvy_reg <= 34'(vy1_reg) * 34'($signed(g.ey));
            pc1_reg <= 34'(vx1_reg) * 34'($signed(g.ey));
            pc2_reg <= 34'(vy1_reg) * 34'($signed(g.ex));
        end
    end

    assign ve = 35'(pvx_reg) + 35'(pvy_reg);

    always_comb
    begin
        d3_next.tz   = (g.ee == '0) || (ve <= 0);
        d3_next.tone = !d3_next.tz && (ve >= $signed({1'b0, g.ee}));
        d3_next.rem  = {1'b0, ve[33:0]};
        d3_next.quo  = '0;
        d3_next.vx   = vx2_reg;
        d3_next.vy   = vy2_reg;
        d3_next.cr   = 35'(pc1_reg) - 35'(pc2_reg);
    end

    div_t d3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d3_reg <= d3_next;
        end
    end

    assign div_s[0] = d3_reg;

    for (genvar i = 0; i < TB; i++)
    begin : g_div
        div_t       st_reg;
        div_t       st_next;
        logic [34:0] r2;

        always_comb
        begin
            r2      = {div_s[i].rem[33:0], 1'b0};
            st_next = div_s[i];
            if (r2 >= {1'b0, g.ee})
            begin
                st_next.rem = r2 - {1'b0, g.ee};
                st_next.quo = {div_s[i].quo[TB-2:0], 1'b1};
            end
            else
            begin
                st_next.rem = r2;
                st_next.quo = {div_s[i].quo[TB-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg <= st_next;
            end
        end

        assign div_s[i+1] = st_reg;
    end

    assign dl = div_s[TB];

    always_comb
    begin
        if (dl.tz)
        begin
            t_val = '0;
        end
        else if (dl.tone)
        begin
            t_val = 31'(1) << TB;
        end
        else
        begin
            t_val = {1'b0, dl.quo};
        end
        absx = g.ex[16] ? 17'(-$signed(g.ex)) : g.ex;
        absy = g.ey[16] ? 17'(-$signed(g.ey)) : g.ey;
        sx   = 17'((magx_reg + (48'(1) << (TB - 1))) >> TB);
        sy   = 17'((magy_reg + (48'(1) << (TB - 1))) >> TB);
        sxs  = negx_reg ? -$signed({1'b0, sx}) : $signed({1'b0, sx});
        sys  = negy_reg ? -$signed({1'b0, sy}) : $signed({1'b0, sy});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            magx_reg <= 48'(absx) * 48'(t_val);
            magy_reg <= 48'(absy) * 48'(t_val);
            negx_reg <= g.ex[16];
            negy_reg <= g.ey[16];
            mvx_reg  <= $signed(dl.vx);
            mvy_reg  <= $signed(dl.vy);
            cr1_reg  <= $signed(dl.cr);
            px_reg   <= 18'(mvx_reg) - sxs;
            py_reg   <= 18'(mvy_reg) - sys;
            cr2_reg  <= cr1_reg;
            sqx_reg  <= 36'(36'(px_reg) * 36'(px_reg));
            sqy_reg  <= 36'(36'(py_reg) * 36'(py_reg));
            cr3_reg  <= cr2_reg;
            d2_reg   <= sqx_reg + sqy_reg;
            cr4_reg  <= cr3_reg;
        end
    end

    assign d2 = d2_reg;
    assign cr = cr4_reg;

endmodule

/* sv/tsd_sqrt.sv */
// Pipelined rounded integer square root, one result bit per stage, with a sign sideband.
// Depends on tsd_pkg.
module tsd_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [tsd_pkg::D2_W-1:0]     n,
    input  tsd_pkg::sign_t               side,
    output logic                         out_valid,
    output logic [tsd_pkg::ROOT_W-1:0]   root,
    output tsd_pkg::sign_t               side_out
);
    localparam int STEPS = tsd_pkg::ROOT_STEPS;
    localparam int W     = tsd_pkg::D2_W;

    typedef struct packed {
        logic [W-1:0]   n;
        logic [W-1:0]   r;
        tsd_pkg::sign_t side;
    } root_t;

    root_t              st_s [STEPS+1];
    logic [STEPS:0]     vld_s;
    root_t              fin_reg;
    logic               fin_vld_reg;
    logic [tsd_pkg::ROOT_W-1:0] root_reg;

    assign st_s[0].n    = n;
    assign st_s[0].r    = '0;
    assign st_s[0].side = side;
    assign vld_s[0]     = in_valid;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic [W-1:0] B = W'(1) << (2 * (STEPS - 1 - i));
        root_t st_reg;
        root_t st_next;
        logic  vld_reg;

        always_comb
        begin
            st_next = st_s[i];
            if (st_s[i].n >= st_s[i].r + B)
            begin
                st_next.n = st_s[i].n - (st_s[i].r + B);
                st_next.r = (st_s[i].r >> 1) + B;
            end
            else
            begin
                st_next.r = st_s[i].r >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg <= st_next;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (en)
            begin
                vld_reg <= vld_s[i];
            end
        end

        assign st_s[i+1]  = st_reg;
        assign vld_s[i+1] = vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fin_reg <= st_s[STEPS];
            if (st_s[STEPS].n > st_s[STEPS].r)
            begin
                root_reg <= tsd_pkg::ROOT_W'(st_s[STEPS].r + 1'b1);
            end
            else
            begin
                root_reg <= tsd_pkg::ROOT_W'(st_s[STEPS].r);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            fin_vld_reg <= vld_s[STEPS];
        end
    end

    assign out_valid = fin_vld_reg;
    assign root      = root_reg;
    assign side_out  = fin_reg.side;

endmodule

/* sv/triangle_signed_distance.sv */
// Top level of the triangle signed distance block: query and result channels, APB registers.
// Depends on tsd_pkg, tsd_query_if, tsd_result_if, tsd_cfg, tsd_edge and tsd_sqrt.
//
//   channel   direction  handshake      payload
//   query     in         valid/ready    query_x, query_y (COORD_BITS each)
//   result    out        valid/ready    signed_distance (18 bits)
//   apb       in         psel/penable   vertex registers at byte addresses 0..20
//
// One query transfer is taken every cycle unless the pipeline is held (see below).
// Each query passes through the 30-stage divider of the edge projection and the 18-stage root.
// All stages advance together and hold while a finished result waits on result.ready.
// Reset clears the valid bits and the vertex registers.
module triangle_signed_distance #(
    parameter int COORD_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    tsd_query_if.sink                   query,
    tsd_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [tsd_pkg::DATA_W-1:0]  pwdata,
    output logic [tsd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    localparam int SHIFT = (COORD_BITS > 16) ? COORD_BITS - 16 : 0;
    localparam int LAT   = tsd_pkg::EDGE_LAT;

    tsd_pkg::geom_t                geom;
    logic                          en;
    logic                          q_vld_reg;
    logic signed [15:0]            qx_reg, qy_reg;
    logic [LAT-1:0]                vchain_reg;
    logic [tsd_pkg::D2_W-1:0]      d2 [3];
    logic signed [34:0]            cr [3];
    logic signed [35:0]            ocr [3];
    logic [tsd_pkg::D2_W-1:0]      best_d2;
    logic signed [35:0]            best_cr;
    logic [tsd_pkg::D2_W-1:0]      best_d2_reg;
    logic signed [35:0]            best_cr_reg;
    logic                          min_vld_reg;
    tsd_pkg::sign_t                best_sign;
    logic                          sq_vld;
    logic [tsd_pkg::ROOT_W-1:0]    root;
    tsd_pkg::sign_t                root_sign;
    logic [39:0]                   dist_mag;
    logic signed [tsd_pkg::OUT_W-1:0] res;
    logic                          out_vld_reg;
    logic [tsd_pkg::OUT_W-1:0]     out_reg;

    assign pready      = 1'b1;
    assign en          = !out_vld_reg || result.ready;
    assign query.ready = en;

    tsd_cfg #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .geom    (geom)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg <= 16'($signed(query.query_x) >>> SHIFT);
            qy_reg <= 16'($signed(query.query_y) >>> SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg   <= 1'b0;
            vchain_reg  <= '0;
            min_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            q_vld_reg   <= query.valid;
            vchain_reg  <= {vchain_reg[LAT-2:0], q_vld_reg};
            min_vld_reg <= vchain_reg[LAT-1];
            out_vld_reg <= sq_vld;
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_edge
        tsd_edge u_edge (
            .clk (clk),
            .en  (en),
            .qx  (qx_reg),
            .qy  (qy_reg),
            .g   (geom.edges[i]),
            .d2  (d2[i]),
            .cr  (cr[i])
        );
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            unique case (geom.orient)
                tsd_pkg::SGN_POS: ocr[i] = 36'(cr[i]);
                tsd_pkg::SGN_NEG: ocr[i] = -36'(cr[i]);
                default:          ocr[i] = '0;
            endcase
        end
        best_d2 = d2[0];
        best_cr = ocr[0];
        for (int i = 1; i < 3; i++)
        begin
            if (d2[i] < best_d2)
            begin
                best_d2 = d2[i];
            end
            if (ocr[i] < best_cr)
            begin
                best_cr = ocr[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            best_d2_reg <= best_d2;
            best_cr_reg <= best_cr;
        end
    end

    always_comb
    begin
        if (best_cr_reg > 0)
        begin
            best_sign = tsd_pkg::SGN_POS;
        end
        else if (best_cr_reg < 0)
        begin
            best_sign = tsd_pkg::SGN_NEG;
        end
        else
        begin
            best_sign = tsd_pkg::SGN_ZERO;
        end
    end

    tsd_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (min_vld_reg),
        .n         (best_d2_reg),
        .side      (best_sign),
        .out_valid (sq_vld),
        .root      (root),
        .side_out  (root_sign)
    );

    always_comb
    begin
        dist_mag = 40'(root) << SHIFT;
        if (dist_mag > 40'(tsd_pkg::OUT_MAX + 1))
        begin
            dist_mag = 40'(tsd_pkg::OUT_MAX + 1);
        end
        unique case (root_sign)
            tsd_pkg::SGN_POS:
            begin
                res = -$signed(tsd_pkg::OUT_W'(dist_mag));
            end
            tsd_pkg::SGN_NEG:
            begin
                if (dist_mag > 40'(tsd_pkg::OUT_MAX))
                begin
                    res = tsd_pkg::OUT_W'(tsd_pkg::OUT_MAX);
                end
                else
                begin
                    res = $signed(tsd_pkg::OUT_W'(dist_mag));
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= res;
        end
    end

    assign result.valid           = out_vld_reg;
    assign result.signed_distance = out_reg;

endmodule
